[src/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Sizes, codes, the ring pointer type and ring arithmetic shared by the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int CAPACITY  = 256;
	localparam int WORD_BITS = 32;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ACT_W  = 4;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_BITS  = ACT_W + WORD_BITS + POS_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = WORD_BITS + STAT_W + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 4'd0,
		ACT_PUSH_BACK  = 4'd1,
		ACT_POP_FRONT  = 4'd2,
		ACT_POP_BACK   = 4'd3,
		ACT_PEEK_FRONT = 4'd4,
		ACT_PEEK_BACK  = 4'd5,
		ACT_READ_AT    = 4'd6,
		ACT_REVERSE    = 4'd7,
		ACT_SORT_CLEAR = 4'd8
	} action_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INDEX = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	// Position codes that select the sub-operation of ACT_SORT_CLEAR.
	localparam logic [POS_W-1:0] SEL_SORT  = 8'd0;
	localparam logic [POS_W-1:0] SEL_CLEAR = 8'd1;

	typedef struct packed {
		logic [ADDR_W-1:0] head;
		logic [CNT_W-1:0]  count;
		logic              rev;
	} ring_ptr_t;

	// Ring index base+off, both below CAPACITY, so one subtract folds it back.
	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
			sum = sum - (ADDR_W + 1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

[src/bdq_slot_map.sv]
// ----------------------------------------------------------------------------
// Deque slot map
// Turns a logical position into a ring entry, honoring the orientation flag.
// ----------------------------------------------------------------------------
module bdq_slot_map (
	input  bdq_pkg::ring_ptr_t         ptr,
	input  logic [bdq_pkg::CNT_W-1:0]  idx,
	output logic [bdq_pkg::ADDR_W-1:0] addr
);
	import bdq_pkg::*;

	logic [CNT_W-1:0] off;

	// Reversed, logical position i sits count-1-i places after the head.
	always_comb begin
		if (ptr.rev) begin
			off = ptr.count - CNT_W'(1) - idx;
		end else begin
			off = idx;
		end
	end

	assign addr = ring_add(ptr.head, off[ADDR_W-1:0]);

endmodule

[src/bounded_deque_with_reverse_and_sort.sv]
// ----------------------------------------------------------------------------
// Bounded deque with reverse and sort
// Double-ended queue of signed words in a ring memory, with sort and reverse.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result transfer. Push, pop, peek,
// read by position, reverse, clear and unknown actions address the element
// memory in the accept cycle; in ST_EXEC the registered read data is used
// and the result is written to the output register once that register is
// free. Sort is a bubble sort over the element memory, which has one read
// and one write port: each pass reads every element once and ends with a
// write-back of the carried word, and up to count passes run. A new item is
// taken while the previous result still waits in the output register. The
// element memory needs no clearing after reset; read data from entries that
// are not live is never used.
module bounded_deque_with_reverse_and_sort (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bdq_pkg::IN_W-1:0]    s_tdata,  // action, value, position
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bdq_pkg::OUT_W-1:0]   m_tdata   // read_value, status, fill_count
);
	import bdq_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_EXEC    = 7'b0000010,
		ST_P_LOAD  = 7'b0000100,
		ST_P_FIRST = 7'b0001000,
		ST_P_CMP   = 7'b0010000,
		ST_P_END   = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t                     state_q;
	ring_ptr_t                  ptr_q;
	ring_ptr_t                  nxt_ptr;
	logic [CNT_W-1:0]           idx_q;
	logic                       swapped_q;
	logic                       m_tvalid_q;

	action_t                    act_s1;
	logic signed [WORD_BITS-1:0] value_s1;
	logic [POS_W-1:0]           pos_s1;

	logic [ACT_W-1:0]           in_action;
	logic [WORD_BITS-1:0]       in_value;
	logic [POS_W-1:0]           in_pos;
	logic [CNT_W-1:0]           in_idx;
	logic [CNT_W-1:0]           map_idx;
	logic                       accept;
	logic                       out_free;
	logic                       res_load;

	logic [WORD_BITS-1:0]       mem [CAPACITY];
	logic [ADDR_W-1:0]          rd_addr;
	logic [ADDR_W-1:0]          rd_addr_s1;
	logic signed [WORD_BITS-1:0] rd_data_q;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [WORD_BITS-1:0]       mem_wdata;

	logic signed [WORD_BITS-1:0] carry_q;
	logic [ADDR_W-1:0]          carry_addr_q;
	logic                       b_less;

	logic                       eff_front;
	logic                       full;
	logic                       empty;
	logic [ADDR_W-1:0]          push_addr;
	logic [WORD_BITS-1:0]       res_value;
	logic [STAT_W-1:0]          res_status;
	logic                       go_sort;

	logic [WORD_BITS-1:0]       out_value_q;
	logic [STAT_W-1:0]          out_status_q;
	logic [CNT_W-1:0]           out_fill_q;

	assign in_action = s_tdata[ACT_W-1:0];
	assign in_value  = s_tdata[ACT_W +: WORD_BITS];
	assign in_pos    = s_tdata[ACT_W + WORD_BITS +: POS_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign res_load = out_free && ((state_q == ST_EXEC && !go_sort) || state_q == ST_DONE);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_fill_q, out_status_q, out_value_q});

	// Pops and peeks read logical position 0 at the front, count-1 at the back.
	always_comb begin
		case (in_action)
			ACT_POP_FRONT, ACT_PEEK_FRONT: in_idx = '0;
			ACT_POP_BACK, ACT_PEEK_BACK:   in_idx = ptr_q.count - CNT_W'(1);
			ACT_READ_AT:                   in_idx = CNT_W'(in_pos);
			default:                       in_idx = '0;
		endcase
	end

	assign map_idx = (state_q == ST_IDLE) ? in_idx : idx_q;

	bdq_slot_map u_slot_map (
		.ptr  (ptr_q),
		.idx  (map_idx),
		.addr (rd_addr)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	// A push at the physical front lands before the head, otherwise after the tail.
	assign eff_front = (~act_s1[0]) ^ ptr_q.rev;
	assign full      = (ptr_q.count == CNT_W'(CAPACITY));
	assign empty     = (ptr_q.count == '0);
	assign push_addr = eff_front ? ring_add(ptr_q.head, ADDR_W'(CAPACITY - 1))
	                             : ring_add(ptr_q.head, ptr_q.count[ADDR_W-1:0]);
	assign b_less    = (carry_q > rd_data_q);

	always_comb begin
		nxt_ptr    = ptr_q;
		res_value  = '0;
		res_status = STAT_OK;
		go_sort    = 1'b0;
		case (act_s1)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					if (eff_front) begin
						nxt_ptr.head = push_addr;
					end
					nxt_ptr.count = ptr_q.count + CNT_W'(1);
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = rd_data_q;
					if (eff_front) begin
						nxt_ptr.head = ring_add(ptr_q.head, ADDR_W'(1));
					end
					nxt_ptr.count = ptr_q.count - CNT_W'(1);
				end
			end
			ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_value = rd_data_q;
				end
			end
			ACT_READ_AT: begin
				if (CMP_W'(pos_s1) >= CMP_W'(ptr_q.count)) begin
					res_status = STAT_INDEX;
				end else begin
					res_value = rd_data_q;
				end
			end
			ACT_REVERSE: begin
				nxt_ptr.rev = ~ptr_q.rev;
			end
			ACT_SORT_CLEAR: begin
				if (pos_s1 == SEL_SORT) begin
					go_sort = (ptr_q.count >= CNT_W'(2));
				end else if (pos_s1 == SEL_CLEAR) begin
					nxt_ptr = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// During a sort pass the larger word of each compared pair is carried in a
	// register; the smaller one is written back to the earlier position.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = push_addr;
		mem_wdata = value_s1;
		case (state_q)
			ST_EXEC: begin
				mem_we = out_free && !full &&
				         (act_s1 == ACT_PUSH_FRONT || act_s1 == ACT_PUSH_BACK);
			end
			ST_P_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = carry_addr_q;
				mem_wdata = b_less ? rd_data_q : carry_q;
			end
			ST_P_END: begin
				mem_we    = 1'b1;
				mem_waddr = carry_addr_q;
				mem_wdata = carry_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			idx_q      <= '0;
			swapped_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= in_idx;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (go_sort) begin
							idx_q   <= '0;
							state_q <= ST_P_LOAD;
						end else begin
							ptr_q   <= nxt_ptr;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_P_LOAD: begin
					swapped_q <= 1'b0;
					idx_q     <= idx_q + CNT_W'(1);
					state_q   <= ST_P_FIRST;
				end
				ST_P_FIRST: begin
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= ST_P_CMP;
				end
				ST_P_CMP: begin
					if (b_less) begin
						swapped_q <= 1'b1;
					end
					if (idx_q < ptr_q.count) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_P_END;
					end
				end
				ST_P_END: begin
					if (swapped_q) begin
						idx_q   <= '0;
						state_q <= ST_P_LOAD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= action_t'(in_action);
			value_s1 <= in_value;
			pos_s1   <= in_pos;
		end
		rd_addr_s1 <= rd_addr;
		if (state_q == ST_P_FIRST) begin
			carry_q      <= rd_data_q;
			carry_addr_q <= rd_addr_s1;
		end else if (state_q == ST_P_CMP) begin
			if (!b_less) begin
				carry_q <= rd_data_q;
			end
			carry_addr_q <= rd_addr_s1;
		end
		if (state_q == ST_EXEC && out_free && !go_sort) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_fill_q   <= nxt_ptr.count;
		end else if (state_q == ST_DONE && out_free) begin
			out_value_q  <= '0;
			out_status_q <= STAT_OK;
			out_fill_q   <= ptr_q.count;
		end
	end

endmodule

[test/bdq_checker.sv]
// ----------------------------------------------------------------------------
// Deque result checker
// Watches both stream channels of the deque. Every input transfer runs
// through a ring-buffer model of the deque that keeps its own head, fill and
// orientation. The outcome is queued, and each result transfer is compared
// field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module bdq_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [bdq_pkg::IN_W-1:0]  s_tdata,   // action, value, position
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [bdq_pkg::OUT_W-1:0] m_tdata,   // read_value, status, fill_count
	output int                        mismatches,
	output int                        outstanding,
	output int                        checked,
	output int                        full_drops,
	output int                        empty_hits,
	output int                        index_errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import bdq_pkg::*;

	localparam int VAL_LSB = ACT_W;
	localparam int POS_LSB = ACT_W + WORD_BITS;

	// Member order puts read_value in the low bits, as on m_tdata.
	typedef struct packed {
		logic [CNT_W-1:0]     fill;
		logic [STAT_W-1:0]    stat;
		logic [WORD_BITS-1:0] word;
	} deque_result_t;

	deque_result_t pending_results[$];

	logic signed [WORD_BITS-1:0] ring [CAPACITY];
	logic [ADDR_W-1:0]           head;
	logic [CNT_W-1:0]            fill;
	logic                        flipped;

	// Ring index of logical position i; while flipped, logical order runs
	// backward from the last live entry.
	function automatic int slot_of(input int i);
		return (int'(head) + (flipped ? int'(fill) - 1 - i : i)) % CAPACITY;
	endfunction

	function automatic deque_result_t apply_op(input logic [ACT_W-1:0] act,
		input logic signed [WORD_BITS-1:0] val, input logic [POS_W-1:0] pos);
		deque_result_t               r;
		logic                        front_end;
		logic                        swapped;
		int                          a;
		int                          b;
		logic signed [WORD_BITS-1:0] t;
		r = '0;
		r.stat = STAT_OK;
		front_end = (act == ACT_PUSH_FRONT || act == ACT_POP_FRONT) ^ flipped;
		case (act)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (fill >= CAPACITY) begin
					r.stat = STAT_FULL;
				end else begin
					if (front_end) begin
						head = ADDR_W'((int'(head) + CAPACITY - 1) % CAPACITY);
						ring[head] = val;
					end else begin
						ring[(int'(head) + int'(fill)) % CAPACITY] = val;
					end
					fill++;
				end
			end
			ACT_POP_FRONT, ACT_POP_BACK: begin
				if (fill == 0) begin
					r.stat = STAT_EMPTY;
				end else if (front_end) begin
					r.word = ring[head];
					head = ADDR_W'((int'(head) + 1) % CAPACITY);
					fill--;
				end else begin
					r.word = ring[(int'(head) + int'(fill) - 1) % CAPACITY];
					fill--;
				end
			end
			ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
				if (fill == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					r.word = ring[slot_of(act == ACT_PEEK_FRONT ? 0 : int'(fill) - 1)];
				end
			end
			ACT_READ_AT: begin
				if (pos >= fill) begin
					r.stat = STAT_INDEX;
				end else begin
					r.word = ring[slot_of(int'(pos))];
				end
			end
			ACT_REVERSE: begin
				flipped = ~flipped;
			end
			ACT_SORT_CLEAR: begin
				if (pos == SEL_SORT && fill > 1) begin
					// Bubble passes in logical order until one pass swaps nothing.
					do begin
						swapped = 1'b0;
						for (int i = 0; i + 1 < int'(fill); i++) begin
							a = slot_of(i);
							b = slot_of(i + 1);
							if (ring[a] > ring[b]) begin
								t = ring[a];
								ring[a] = ring[b];
								ring[b] = t;
								swapped = 1'b1;
							end
						end
					end while (swapped);
				end else if (pos == SEL_CLEAR) begin
					head = '0;
					fill = '0;
					flipped = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.fill = fill;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		deque_result_t got;
		if (!arst_n) begin
			head = '0;
			fill = '0;
			flipped = 1'b0;
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
			full_drops = 0;
			empty_hits = 0;
			index_errors = 0;
		end else begin
			// Results first: an input taken at this edge cannot be answered at it.
			if (m_tvalid && m_tready) begin
				got = deque_result_t'(m_tdata[OUT_BITS-1:0]);
				checked++;
				if (pending_results.size() == 0) begin
					mismatches++;
					$error("result transfer with no operation outstanding");
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (got.word !== want.word) begin
						mismatches++;
						$error("read_value mismatch: expected %0d, got %0d",
							$signed(want.word), $signed(got.word));
					end
					if (got.stat !== want.stat) begin
						mismatches++;
						$error("status mismatch: expected %0d, got %0d", want.stat, got.stat);
					end
					if (got.fill !== want.fill) begin
						mismatches++;
						$error("fill_count mismatch: expected %0d, got %0d",
							want.fill, got.fill);
					end
					if (want.stat == STAT_FULL) begin
						full_drops++;
					end
					if (want.stat == STAT_EMPTY) begin
						empty_hits++;
					end
					if (want.stat == STAT_INDEX) begin
						index_errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.insert(pending_results.size(), apply_op(s_tdata[ACT_W-1:0],
					s_tdata[VAL_LSB+WORD_BITS-1:VAL_LSB], s_tdata[POS_LSB+POS_W-1:POS_LSB]));
			end
			outstanding = pending_results.size();
		end
	end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Deque testbench top
// Drives operations into the deque and takes its results with random gaps on
// both sides. The stimulus covers the empty, full and index-error cases, an
// ignored-action sweep, sorts up to a full store, and a long receiver stall.
// The checker does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bdq_pkg::*;

	localparam int STALL_LIMIT = 300000;
	localparam int RANDOM_OPS  = 1150;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 400;

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
	localparam logic [ACT_W-1:0]     ACT_LAST_CODE = '1;
	localparam logic [POS_W-1:0]     POS_LAST = '1;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int checked;
	int full_drops;
	int empty_hits;
	int index_errors;
	int ops_sent;
	int sorts_sent;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	bounded_deque_with_reverse_and_sort u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bdq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked),
		.full_drops   (full_drops),
		.empty_hits   (empty_hits),
		.index_errors (index_errors)
	);

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_op(input logic [ACT_W-1:0] act, input logic [WORD_BITS-1:0] val,
		input logic [POS_W-1:0] pos);
		int gap;
		gap = ((ops_sent / 200) % 3 == 2) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({pos, val, act});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		ops_sent++;
		if (act == ACT_SORT_CLEAR && pos == SEL_SORT) begin
			sorts_sent++;
		end
	endtask

	// Small values make duplicates for the sorts; extremes hit the sign boundary.
	function automatic logic [WORD_BITS-1:0] draw_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3: return WORD_BITS'($urandom_range(0, 15)) - WORD_BITS'(8);
			default: return WORD_BITS'($urandom());
		endcase
	endfunction

	task automatic random_op(input logic push_heavy);
		int                 r;
		logic [ACT_W-1:0]   act;
		logic [POS_W-1:0]   pos;
		r = $urandom_range(0, 99);
		pos = POS_W'($urandom());
		if (r < (push_heavy ? 45 : 25)) begin
			act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		end else if (r < 60) begin
			act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
		end else if (r < 68) begin
			act = $urandom_range(0, 1) ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
		end else if (r < 82) begin
			act = ACT_READ_AT;
			if ($urandom_range(0, 3) != 0) begin
				pos = POS_W'($urandom_range(0, 48));
			end
		end else if (r < 88) begin
			act = ACT_REVERSE;
		end else if (r < 91) begin
			act = ACT_SORT_CLEAR;
			pos = SEL_SORT;
		end else if (r < 93) begin
			act = ACT_SORT_CLEAR;
			pos = SEL_CLEAR;
		end else if (r < 96) begin
			act = ACT_SORT_CLEAR;
			pos = POS_W'($urandom_range(SEL_CLEAR + 1, POS_LAST));
		end else begin
			act = ACT_W'($urandom_range(ACT_SORT_CLEAR + 1, ACT_LAST_CODE));
		end
		send_op(act, draw_word(), pos);
	endtask

	// Result side, with one long hold-off that backs the deque up into its input.
	initial begin
		int taken;
		int gap;
		m_tready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = ((taken / 250) % 3 == 1) ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
			taken++;
		end
	end

	// A long stretch without any transfer on either side means the deque hung.
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$error("no transfer for %0d cycles, outstanding results %0d", STALL_LIMIT, outstanding);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		ops_sent = 0;
		sorts_sent = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty deque: every read-type operation reports, sort does nothing, reverse flips the orientation.
		send_op(ACT_POP_FRONT, draw_word(), '0);
		send_op(ACT_POP_BACK, draw_word(), '0);
		send_op(ACT_PEEK_FRONT, draw_word(), '0);
		send_op(ACT_PEEK_BACK, draw_word(), '0);
		send_op(ACT_READ_AT, draw_word(), '0);
		send_op(ACT_SORT_CLEAR, draw_word(), SEL_SORT);
		send_op(ACT_REVERSE, draw_word(), '0);
		// A push at the back while reversed lands at the forward front.
		send_op(ACT_PUSH_BACK, WORD_MAX, '0);
		send_op(ACT_REVERSE, draw_word(), '0);
		send_op(ACT_PUSH_BACK, WORD_MIN, '0);
		send_op(ACT_PUSH_FRONT, '0, '0);
		send_op(ACT_PUSH_FRONT, '1, '0);
		send_op(ACT_SORT_CLEAR, draw_word(), SEL_SORT);
		send_op(ACT_READ_AT, draw_word(), '0);
		send_op(ACT_READ_AT, draw_word(), POS_W'(4));
		send_op(ACT_READ_AT, draw_word(), POS_LAST);
		send_op(ACT_REVERSE, draw_word(), '0);
		send_op(ACT_PEEK_FRONT, draw_word(), '0);
		send_op(ACT_PEEK_BACK, draw_word(), '0);
		send_op(ACT_PUSH_FRONT, draw_word(), '0);
		send_op(ACT_PUSH_BACK, draw_word(), '0);
		send_op(ACT_POP_FRONT, draw_word(), '0);
		send_op(ACT_POP_BACK, draw_word(), '0);
		send_op(ACT_SORT_CLEAR, draw_word(), POS_LAST);
		send_op(ACT_LAST_CODE, draw_word(), POS_LAST);
		send_op(ACT_SORT_CLEAR, draw_word(), SEL_CLEAR);

		// Fill to capacity and past it, then one sort over the whole store.
		for (int i = 0; i < CAPACITY + 4; i++) begin
			send_op($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, draw_word(),
				POS_W'($urandom()));
		end
		send_op(ACT_READ_AT, draw_word(), POS_W'(CAPACITY - 1));
		send_op(ACT_SORT_CLEAR, draw_word(), SEL_SORT);
		send_op(ACT_PEEK_FRONT, draw_word(), '0);
		send_op(ACT_PEEK_BACK, draw_word(), '0);
		send_op(ACT_REVERSE, draw_word(), '0);
		send_op(ACT_READ_AT, draw_word(), '0);
		send_op(ACT_POP_BACK, draw_word(), '0);
		send_op(ACT_PUSH_FRONT, draw_word(), '0);
		send_op(ACT_PUSH_BACK, draw_word(), '0);
		send_op(ACT_SORT_CLEAR, draw_word(), SEL_CLEAR);

		// Alternate push-heavy and pop-heavy stretches so the fill rises and drains.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			random_op(((n / 80) % 2) == 0);
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d operations including %0d sorts; %0d results compared.",
			ops_sent, sorts_sent, checked);
		$display("Seen: %0d pushes dropped when full, %0d empty reads, %0d bad positions.",
			full_drops, empty_hits, index_errors);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
